>>> design/text_console_cursor_scroll_core_defines.svh
// Assertion helpers for the console modules; tccs_back includes them.
// Each macro expects clk and rst_n in scope.
`ifndef TEXT_CONSOLE_CURSOR_SCROLL_CORE_DEFINES_SVH
`define TEXT_CONSOLE_CURSOR_SCROLL_CORE_DEFINES_SVH

// Same-cycle implication.
`define TCCS_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define TCCS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> design/tccs_pkg.sv
package tccs_pkg;

  localparam int SCREEN_COLS = 80;
  localparam int SCREEN_ROWS = 25;
  localparam int CELL_COUNT  = SCREEN_ROWS * SCREEN_COLS;
  localparam int ADDR_W      = $clog2(CELL_COUNT);
  localparam int ROW_W       = 5;
  localparam int COL_W       = 7;
  localparam int CELL_W      = 16;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [7:0] BLANK_CHAR   = 8'h20;
  localparam logic [7:0] RESET_ATTR   = 8'h07;
  localparam logic [7:0] CODE_NEWLINE = 8'd10;
  localparam logic [7:0] CODE_RETURN  = 8'd13;

  localparam logic [1:0] REQ_PUT   = 2'd0;
  localparam logic [1:0] REQ_READ  = 2'd1;
  localparam logic [1:0] REQ_CLEAR = 2'd2;

  localparam logic [ROW_W-1:0]  LAST_ROW     = ROW_W'(SCREEN_ROWS - 1);
  localparam logic [COL_W-1:0]  WRAP_COL     = COL_W'(SCREEN_COLS);
  localparam logic [ADDR_W-1:0] COLS_ADDR    = ADDR_W'(SCREEN_COLS);
  localparam logic [ADDR_W-1:0] LAST_CELL    = ADDR_W'(CELL_COUNT - 1);
  localparam logic [ADDR_W-1:0] COPY_LAST    = ADDR_W'(CELL_COUNT - SCREEN_COLS - 1);
  localparam logic [ADDR_W-1:0] BOTTOM_START = ADDR_W'(CELL_COUNT - SCREEN_COLS);

  typedef enum logic [2:0] {
    OP_CHAR,
    OP_NEWLINE,
    OP_RETURN,
    OP_READ,
    OP_CLEAR,
    OP_NOP
  } op_t;

  typedef struct packed {
    op_t               op;
    logic [7:0]        ch;
    logic [ADDR_W-1:0] addr;
    logic              in_range;
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_COPY,
    ST_FILL,
    ST_PUT,
    ST_CLEAR
  } state_t;

endpackage

>>> design/tccs_front.sv
module tccs_front import tccs_pkg::*; (
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [1:0]       in_req_type,
  input  logic [7:0]       in_char_code,
  input  logic [ROW_W-1:0] in_read_row,
  input  logic [COL_W-1:0] in_read_col,
  input  logic             init_done,
  output logic             push_valid,
  input  logic             push_ready,
  output cmd_t             push_cmd
);

  logic in_range;

  // No request is taken while the store is being blanked after reset.
  assign in_ready   = push_ready && init_done;
  assign push_valid = in_valid && init_done;

  assign in_range = (in_read_row < ROW_W'(SCREEN_ROWS)) && (in_read_col < WRAP_COL);

  always_comb begin
    push_cmd.ch       = in_char_code;
    push_cmd.in_range = in_range;
    push_cmd.addr     = in_range ?
                        ADDR_W'(ADDR_W'(in_read_row) * COLS_ADDR + ADDR_W'(in_read_col)) :
                        '0;
    unique case (in_req_type)
      REQ_PUT: begin
        if (in_char_code == CODE_NEWLINE) begin
          push_cmd.op = OP_NEWLINE;
        end else if (in_char_code == CODE_RETURN) begin
          push_cmd.op = OP_RETURN;
        end else begin
          push_cmd.op = OP_CHAR;
        end
      end
      REQ_READ:  push_cmd.op = OP_READ;
      REQ_CLEAR: push_cmd.op = OP_CLEAR;
      default:   push_cmd.op = OP_NOP;
    endcase
  end

endmodule

>>> design/tccs_queue.sv
module tccs_queue import tccs_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push_valid,
  output logic push_ready,
  input  cmd_t push_cmd,
  output logic pop_valid,
  input  logic pop_ready,
  output cmd_t pop_cmd
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  cmd_t             q_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wptr_r, wptr_nxt;
  logic [PTR_W-1:0] rptr_r, rptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push, do_pop;

  assign push_ready = count_r != CNT_W'(QUEUE_DEPTH);
  assign pop_valid  = count_r != '0;
  assign pop_cmd    = q_r[rptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_comb begin
    wptr_nxt  = wptr_r;
    rptr_nxt  = rptr_r;
    count_nxt = count_r;
    if (do_push) begin
      wptr_nxt = (wptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wptr_r + PTR_W'(1);
    end
    if (do_pop) begin
      rptr_nxt = (rptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rptr_r + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      wptr_r  <= wptr_nxt;
      rptr_r  <= rptr_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      q_r[wptr_r] <= push_cmd;
    end
  end

endmodule

>>> design/tccs_back.sv
`include "text_console_cursor_scroll_core_defines.svh"

module tccs_back import tccs_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             pop_valid,
  output logic             pop_ready,
  input  cmd_t             pop_cmd,
  output logic             init_done,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [7:0]       cfg_text_attr,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [7:0]       out_cell_char,
  output logic [7:0]       out_cell_attr,
  output logic [ROW_W-1:0] out_cursor_row,
  output logic [COL_W-1:0] out_cursor_col
);

  state_t state_r, state_nxt;

  logic [ROW_W-1:0]  row_r, row_nxt;
  logic [COL_W-1:0]  col_r, col_nxt;
  logic [7:0]        attr_r;
  logic [ADDR_W-1:0] cnt_r, cnt_nxt;
  logic              copy_v_r;
  logic [ADDR_W-1:0] copy_a_r;
  logic [CELL_W-1:0] fill_cell_r, fill_nxt;
  logic              clr_item_r, clr_item_nxt;
  logic              pend_put_r, pend_nxt;
  logic [7:0]        put_char_r, pchar_nxt;
  logic              rd_ok_r, rd_ok_nxt;
  logic              init_done_r, init_nxt;

  logic [CELL_W-1:0] mem_r [CELL_COUNT];
  logic [CELL_W-1:0] rdata_r;
  logic              we;
  logic [ADDR_W-1:0] waddr, raddr;
  logic [CELL_W-1:0] wdata;

  logic              out_valid_r;
  logic [7:0]        out_char_r, out_attr_r;
  logic [ROW_W-1:0]  out_row_r;
  logic [COL_W-1:0]  out_col_r;

  logic              slot_free, take, wrap, at_bottom, char_scroll;
  logic [ROW_W-1:0]  eff_row;
  logic [COL_W-1:0]  eff_col;
  logic [ADDR_W-1:0] char_addr;
  logic              finish;
  logic [7:0]        res_char, res_attr;

  assign cfg_ready      = 1'b1;
  assign init_done      = init_done_r;
  assign out_valid      = out_valid_r;
  assign out_cell_char  = out_char_r;
  assign out_cell_attr  = out_attr_r;
  assign out_cursor_row = out_row_r;
  assign out_cursor_col = out_col_r;

  // A request is only taken when its result will find the output register free.
  assign slot_free   = !out_valid_r || out_ready;
  assign take        = (state_r == ST_IDLE) && pop_valid && slot_free;
  assign wrap        = col_r >= WRAP_COL;
  assign at_bottom   = row_r == LAST_ROW;
  assign char_scroll = wrap && at_bottom;
  assign eff_row     = wrap ? row_r + ROW_W'(1) : row_r;
  assign eff_col     = wrap ? '0 : col_r;
  assign char_addr   = ADDR_W'(ADDR_W'(eff_row) * COLS_ADDR + ADDR_W'(eff_col));

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (take) begin
          unique case (pop_cmd.op)
            OP_READ:    state_nxt = ST_READ;
            OP_CLEAR:   state_nxt = ST_CLEAR;
            OP_NEWLINE: state_nxt = at_bottom ? ST_COPY : ST_IDLE;
            OP_CHAR:    state_nxt = char_scroll ? ST_COPY : ST_IDLE;
            default:    state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_READ:  state_nxt = ST_IDLE;
      ST_COPY:  state_nxt = (cnt_r == COPY_LAST) ? ST_FILL : ST_COPY;
      ST_FILL: begin
        if (!copy_v_r && cnt_r == LAST_CELL) begin
          state_nxt = pend_put_r ? ST_PUT : ST_IDLE;
        end
      end
      ST_PUT:   state_nxt = ST_IDLE;
      ST_CLEAR: state_nxt = (cnt_r == LAST_CELL) ? ST_IDLE : ST_CLEAR;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    pop_ready    = 1'b0;
    we           = 1'b0;
    waddr        = cnt_r;
    wdata        = fill_cell_r;
    raddr        = pop_cmd.addr;
    row_nxt      = row_r;
    col_nxt      = col_r;
    cnt_nxt      = cnt_r;
    finish       = 1'b0;
    res_char     = '0;
    res_attr     = '0;
    fill_nxt     = fill_cell_r;
    clr_item_nxt = clr_item_r;
    pend_nxt     = pend_put_r;
    pchar_nxt    = put_char_r;
    rd_ok_nxt    = rd_ok_r;
    init_nxt     = init_done_r;
    unique case (state_r)
      ST_IDLE: begin
        pop_ready = slot_free;
        if (take) begin
          unique case (pop_cmd.op)
            OP_CHAR: begin
              if (char_scroll) begin
                // The character goes to the bottom row once the scroll is done.
                col_nxt   = '0;
                pend_nxt  = 1'b1;
                pchar_nxt = pop_cmd.ch;
                cnt_nxt   = '0;
                fill_nxt  = {attr_r, BLANK_CHAR};
              end else begin
                we      = 1'b1;
                waddr   = char_addr;
                wdata   = {attr_r, pop_cmd.ch};
                row_nxt = eff_row;
                col_nxt = eff_col + COL_W'(1);
                finish  = 1'b1;
              end
            end
            OP_NEWLINE: begin
              col_nxt = '0;
              if (at_bottom) begin
                pend_nxt = 1'b0;
                cnt_nxt  = '0;
                fill_nxt = {attr_r, BLANK_CHAR};
              end else begin
                row_nxt = row_r + ROW_W'(1);
                finish  = 1'b1;
              end
            end
            OP_RETURN: begin
              col_nxt = '0;
              finish  = 1'b1;
            end
            OP_READ: begin
              rd_ok_nxt = pop_cmd.in_range;
            end
            OP_CLEAR: begin
              cnt_nxt      = '0;
              fill_nxt     = {attr_r, BLANK_CHAR};
              clr_item_nxt = 1'b1;
            end
            default: finish = 1'b1;
          endcase
        end
      end
      ST_READ: begin
        finish = 1'b1;
        if (rd_ok_r) begin
          res_char = rdata_r[7:0];
          res_attr = rdata_r[15:8];
        end
      end
      ST_COPY: begin
        // Each row moves up one: read a cell a row below, then write the registered data to the row above.
        raddr   = cnt_r + COLS_ADDR;
        cnt_nxt = (cnt_r == COPY_LAST) ? BOTTOM_START : cnt_r + ADDR_W'(1);
        if (copy_v_r) begin
          we    = 1'b1;
          waddr = copy_a_r;
          wdata = rdata_r;
        end
      end
      ST_FILL: begin
        if (copy_v_r) begin
          we    = 1'b1;
          waddr = copy_a_r;
          wdata = rdata_r;
        end else begin
          we = 1'b1;
          if (cnt_r == LAST_CELL) begin
            finish = !pend_put_r;
          end else begin
            cnt_nxt = cnt_r + ADDR_W'(1);
          end
        end
      end
      ST_PUT: begin
        we       = 1'b1;
        waddr    = BOTTOM_START;
        wdata    = {attr_r, put_char_r};
        col_nxt  = COL_W'(1);
        pend_nxt = 1'b0;
        finish   = 1'b1;
      end
      ST_CLEAR: begin
        we = 1'b1;
        if (cnt_r == LAST_CELL) begin
          init_nxt = 1'b1;
          if (clr_item_r) begin
            row_nxt      = '0;
            col_nxt      = '0;
            finish       = 1'b1;
            clr_item_nxt = 1'b0;
          end
        end else begin
          cnt_nxt = cnt_r + ADDR_W'(1);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      row_r       <= '0;
      col_r       <= '0;
      attr_r      <= RESET_ATTR;
      cnt_r       <= '0;
      copy_v_r    <= 1'b0;
      fill_cell_r <= {RESET_ATTR, BLANK_CHAR};
      clr_item_r  <= 1'b0;
      pend_put_r  <= 1'b0;
      rd_ok_r     <= 1'b0;
      init_done_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      row_r       <= row_nxt;
      col_r       <= col_nxt;
      cnt_r       <= cnt_nxt;
      copy_v_r    <= state_r == ST_COPY;
      fill_cell_r <= fill_nxt;
      clr_item_r  <= clr_item_nxt;
      pend_put_r  <= pend_nxt;
      rd_ok_r     <= rd_ok_nxt;
      init_done_r <= init_nxt;
      if (cfg_valid && cfg_ready) begin
        attr_r <= cfg_text_attr;
      end
      if (finish) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    copy_a_r   <= cnt_r;
    put_char_r <= pchar_nxt;
    if (finish) begin
      out_char_r <= res_char;
      out_attr_r <= res_attr;
      out_row_r  <= row_nxt;
      out_col_r  <= col_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  `TCCS_ASSERT_IMPL(a_pop_when_free, pop_valid && pop_ready, state_r == ST_IDLE && slot_free, "request taken while busy")
  `TCCS_ASSERT_IMPL(a_no_overwrite, finish, !out_valid_r || out_ready, "result register overwritten")
  `TCCS_ASSERT_IMPL(a_cursor_range, 1'b1, row_r <= LAST_ROW && col_r <= WRAP_COL, "cursor out of range")
  `TCCS_ASSERT_NEXT(a_init_sticky, init_done_r, init_done_r, "store init flag dropped")

endmodule

>>> design/text_console_cursor_scroll_core.sv
// Text console engine: an 80 x 25 character-cell store with a cursor.
// Input channel (in_valid/in_ready): one request per transfer, in_req_type
// selects put character, read cell or clear screen; unused codes only report
// the cursor. Output channel (out_valid/out_ready): exactly one result per
// request, in order, with the read cell (zero otherwise) and the cursor after
// the request. cfg_valid/cfg_ready writes the attribute byte used for every
// written character and blank; cfg_ready is always high.
// A scroll copies 1920 cells one per cycle through the store's single read
// and write port and then blanks 80 cells of the bottom row. While out_ready
// stays high and nothing scrolls, one simple request completes per cycle; a
// read is finished before the next request is taken. After reset the store
// is blanked to spaces with attribute 0x07, during which in_ready is low. A
// two-entry request queue sits between decode and execution; when the
// receiver stalls the result is held in the output register and execution
// waits, while the queue keeps taking requests until it is full.
module text_console_cursor_scroll_core import tccs_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [1:0]       in_req_type,
  input  logic [7:0]       in_char_code,
  input  logic [ROW_W-1:0] in_read_row,
  input  logic [COL_W-1:0] in_read_col,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [7:0]       cfg_text_attr,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [7:0]       out_cell_char,
  output logic [7:0]       out_cell_attr,
  output logic [ROW_W-1:0] out_cursor_row,
  output logic [COL_W-1:0] out_cursor_col
);

  logic init_done;
  logic push_valid, push_ready;
  logic pop_valid, pop_ready;
  cmd_t push_cmd, pop_cmd;

  tccs_front u_front (
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_req_type  (in_req_type),
    .in_char_code (in_char_code),
    .in_read_row  (in_read_row),
    .in_read_col  (in_read_col),
    .init_done    (init_done),
    .push_valid   (push_valid),
    .push_ready   (push_ready),
    .push_cmd     (push_cmd)
  );

  tccs_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_cmd   (push_cmd),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_cmd    (pop_cmd)
  );

  tccs_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .pop_valid      (pop_valid),
    .pop_ready      (pop_ready),
    .pop_cmd        (pop_cmd),
    .init_done      (init_done),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_text_attr  (cfg_text_attr),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_cell_char  (out_cell_char),
    .out_cell_attr  (out_cell_attr),
    .out_cursor_row (out_cursor_row),
    .out_cursor_col (out_cursor_col)
  );

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import tccs_pkg::*;

  localparam logic [1:0] REQ_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT = 5_000_000;

  typedef struct packed {
    logic [1:0]       req_type;
    logic [7:0]       char_code;
    logic [ROW_W-1:0] read_row;
    logic [COL_W-1:0] read_col;
  } console_req_t;

  typedef struct packed {
    logic [7:0]       cell_char;
    logic [7:0]       cell_attr;
    logic [ROW_W-1:0] cursor_row;
    logic [COL_W-1:0] cursor_col;
  } console_result_t;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_valid = 1'b0;
  logic             in_ready;
  logic [1:0]       in_req_type = '0;
  logic [7:0]       in_char_code = '0;
  logic [ROW_W-1:0] in_read_row = '0;
  logic [COL_W-1:0] in_read_col = '0;
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  logic [7:0]       cfg_text_attr = '0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  logic [7:0]       out_cell_char;
  logic [7:0]       out_cell_attr;
  logic [ROW_W-1:0] out_cursor_row;
  logic [COL_W-1:0] out_cursor_col;

  // Shadow of the console state.
  logic [15:0] screen_shadow [CELL_COUNT];
  int          shadow_row;
  int          shadow_col;
  logic [7:0]  text_attr_now;

  console_result_t pending_results [$];

  int tx_max_gap   = 0;
  int rx_max_stall = 0;
  int errors       = 0;
  int cycle_count  = 0;
  int n_requests   = 0;
  int n_reads      = 0;
  int n_clears     = 0;
  int n_scrolls    = 0;
  int n_checked    = 0;

  text_console_cursor_scroll_core dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_req_type    (in_req_type),
    .in_char_code   (in_char_code),
    .in_read_row    (in_read_row),
    .in_read_col    (in_read_col),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_text_attr  (cfg_text_attr),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_cell_char  (out_cell_char),
    .out_cell_attr  (out_cell_attr),
    .out_cursor_row (out_cursor_row),
    .out_cursor_col (out_cursor_col)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  function automatic void blank_screen(input logic [7:0] attr);
    for (int i = 0; i < CELL_COUNT; i++) screen_shadow[i] = {attr, BLANK_CHAR};
  endfunction

  function automatic void next_line();
    shadow_col = 0;
    shadow_row++;
    if (shadow_row >= SCREEN_ROWS) begin
      for (int i = 0; i < CELL_COUNT - SCREEN_COLS; i++)
        screen_shadow[i] = screen_shadow[i + SCREEN_COLS];
      for (int i = CELL_COUNT - SCREEN_COLS; i < CELL_COUNT; i++)
        screen_shadow[i] = {text_attr_now, BLANK_CHAR};
      shadow_row = SCREEN_ROWS - 1;
      n_scrolls++;
    end
  endfunction

  function automatic console_result_t predict_request(input console_req_t r);
    console_result_t res;
    logic [15:0]     cell_word;
    res = '0;
    case (r.req_type)
      REQ_PUT: begin
        if (r.char_code == CODE_NEWLINE) begin
          next_line();
        end else if (r.char_code == CODE_RETURN) begin
          shadow_col = 0;
        end else begin
          // A column equal to the width means the wrap is still pending.
          if (shadow_col >= SCREEN_COLS) next_line();
          screen_shadow[shadow_row * SCREEN_COLS + shadow_col] = {text_attr_now, r.char_code};
          shadow_col++;
        end
      end
      REQ_READ: begin
        n_reads++;
        if (r.read_row < SCREEN_ROWS && r.read_col < SCREEN_COLS) begin
          cell_word = screen_shadow[r.read_row * SCREEN_COLS + r.read_col];
          res.cell_char = cell_word[7:0];
          res.cell_attr = cell_word[15:8];
        end
      end
      REQ_CLEAR: begin
        n_clears++;
        blank_screen(text_attr_now);
        shadow_row = 0;
        shadow_col = 0;
      end
      default: ;
    endcase
    res.cursor_row = shadow_row[ROW_W-1:0];
    res.cursor_col = shadow_col[COL_W-1:0];
    return res;
  endfunction

  function automatic logic [7:0] printable_byte();
    logic [7:0] b;
    b = 8'($urandom_range(0, 255));
    if (b == CODE_NEWLINE || b == CODE_RETURN) b = 8'h2A;
    return b;
  endfunction

  task automatic send_request(input logic [1:0] req, input logic [7:0] ch,
                              input logic [ROW_W-1:0] row, input logic [COL_W-1:0] col);
    console_req_t r;
    int           gap;
    r = '{req, ch, row, col};
    gap = (tx_max_gap == 0) ? 0 : $urandom_range(0, tx_max_gap);
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid     <= 1'b1;
    in_req_type  <= req;
    in_char_code <= ch;
    in_read_row  <= row;
    in_read_col  <= col;
    do @(posedge clk); while (!in_ready);
    n_requests++;
    pending_results.push_back(predict_request(r));
  endtask

  task automatic put_char(input logic [7:0] ch);
    send_request(REQ_PUT, ch, ROW_W'($urandom_range(0, 31)), COL_W'($urandom_range(0, 127)));
  endtask

  task automatic read_cell(input int row, input int col);
    send_request(REQ_READ, 8'($urandom_range(0, 255)), ROW_W'(row), COL_W'(col));
  endtask

  task automatic wait_results_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic set_text_attr(input logic [7:0] value);
    wait_results_drained();
    @(negedge clk);
    cfg_valid     <= 1'b1;
    cfg_text_attr <= value;
    do @(posedge clk); while (!cfg_ready);
    text_attr_now = value;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Result side: a random stall before each result is taken.
  initial begin
    int n;
    forever begin
      n = (rx_max_stall == 0) ? 0 : $urandom_range(0, rx_max_stall);
      if (n > 0) begin
        @(negedge clk);
        out_ready <= 1'b0;
        repeat (n - 1) @(negedge clk);
      end
      @(negedge clk);
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  function automatic void check_field(input string name, input int expected, input int actual);
    if (expected != actual) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, expected, actual);
    end
  endfunction

  always @(posedge clk) begin
    console_result_t exp_res;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, got char %0d attr %0d cursor %0d,%0d",
                 $time, out_cell_char, out_cell_attr, out_cursor_row, out_cursor_col);
      end else begin
        exp_res = pending_results.pop_front();
        n_checked++;
        check_field("cell_char", int'(exp_res.cell_char), int'(out_cell_char));
        check_field("cell_attr", int'(exp_res.cell_attr), int'(out_cell_attr));
        check_field("cursor_row", int'(exp_res.cursor_row), int'(out_cursor_row));
        check_field("cursor_col", int'(exp_res.cursor_col), int'(out_cursor_col));
      end
    end
  end

  task automatic test_reset_contents();
    read_cell(0, 0);
    read_cell(SCREEN_ROWS - 1, SCREEN_COLS - 1);
    read_cell(12, 40);
  endtask

  task automatic test_read_bounds();
    read_cell(SCREEN_ROWS, 0);
    read_cell(31, 127);
    read_cell(0, SCREEN_COLS);
    read_cell(SCREEN_ROWS - 1, 127);
  endtask

  task automatic test_put_controls();
    set_text_attr(8'h00);
    put_char(8'h41);
    put_char(8'h00);
    put_char(8'hFF);
    put_char(CODE_RETURN);
    put_char(8'h7E);
    put_char(CODE_NEWLINE);
    read_cell(0, 0);
    read_cell(0, 1);
    read_cell(0, 2);
  endtask

  task automatic test_unused_request();
    send_request(REQ_UNUSED, 8'hFF, 5'd31, 7'd127);
    send_request(REQ_UNUSED, 8'h00, 5'd0, 7'd0);
  endtask

  task automatic test_clear();
    set_text_attr(8'hFF);
    send_request(REQ_CLEAR, 8'($urandom_range(0, 255)), ROW_W'($urandom_range(0, 31)),
                 COL_W'($urandom_range(0, 127)));
    read_cell(0, 0);
    read_cell(5, 5);
  endtask

  task automatic test_line_wrap();
    send_request(REQ_CLEAR, 8'h00, 5'd0, 7'd0);
    repeat (SCREEN_COLS) put_char(printable_byte());
    read_cell(0, SCREEN_COLS - 1);
    // Carriage return while the wrap is pending goes back to the same row.
    put_char(CODE_RETURN);
    repeat (SCREEN_COLS) put_char(printable_byte());
    put_char(printable_byte());
    read_cell(0, 0);
    read_cell(1, 0);
    repeat (SCREEN_COLS - 1) put_char(printable_byte());
    put_char(CODE_NEWLINE);
    read_cell(1, SCREEN_COLS - 1);
  endtask

  task automatic test_scroll();
    set_text_attr(8'($urandom_range(0, 255)));
    send_request(REQ_CLEAR, 8'h00, 5'd0, 7'd0);
    put_char(CODE_NEWLINE);
    put_char(printable_byte());
    repeat (SCREEN_ROWS - 2) put_char(CODE_NEWLINE);
    put_char(CODE_NEWLINE);
    read_cell(0, 0);
    read_cell(SCREEN_ROWS - 1, 10);
    set_text_attr(8'($urandom_range(0, 255)));
    put_char(CODE_NEWLINE);
    read_cell(SCREEN_ROWS - 1, SCREEN_COLS - 1);
    read_cell(SCREEN_ROWS - 2, SCREEN_COLS - 1);
    // Fill the bottom row, then one more byte scrolls through the wrap.
    repeat (SCREEN_COLS) put_char(printable_byte());
    put_char(printable_byte());
    read_cell(SCREEN_ROWS - 2, 0);
    read_cell(SCREEN_ROWS - 2, SCREEN_COLS - 1);
    read_cell(SCREEN_ROWS - 1, 0);
    read_cell(SCREEN_ROWS - 1, 1);
  endtask

  task automatic test_random_traffic(input int count, input int tx_gap, input int rx_gap,
                                     input bit drain_often);
    logic [1:0]       req;
    logic [7:0]       ch;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    int               pick;
    int               sel;
    tx_max_gap   = tx_gap;
    rx_max_stall = rx_gap;
    for (int i = 0; i < count; i++) begin
      ch   = 8'($urandom_range(0, 255));
      row  = ROW_W'($urandom_range(0, 31));
      col  = COL_W'($urandom_range(0, 127));
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        req = REQ_PUT;
        sel = $urandom_range(0, 19);
        if (sel < 2) ch = CODE_NEWLINE;
        else if (sel == 2) ch = CODE_RETURN;
      end else if (pick < 92) begin
        req = REQ_READ;
        sel = $urandom_range(0, 9);
        // Half of the reads look at the cursor's row, where the writes land.
        if (sel < 5) begin
          row = ROW_W'(shadow_row);
          col = COL_W'($urandom_range(0, SCREEN_COLS - 1));
        end else if (sel < 9) begin
          row = ROW_W'($urandom_range(0, SCREEN_ROWS - 1));
          col = COL_W'($urandom_range(0, SCREEN_COLS - 1));
        end
      end else if (pick < 94) begin
        req = REQ_CLEAR;
      end else if (pick < 97) begin
        req = REQ_UNUSED;
      end else begin
        req = REQ_PUT;
      end
      send_request(req, ch, row, col);
      if (drain_often && (i % 25) == 24) wait_results_drained();
    end
  endtask

  initial begin
    blank_screen(RESET_ATTR);
    shadow_row    = 0;
    shadow_col    = 0;
    text_attr_now = RESET_ATTR;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_reset_contents();
    test_read_bounds();
    test_put_controls();
    test_unused_request();
    test_clear();

    tx_max_gap   = 12;
    rx_max_stall = 12;
    test_line_wrap();
    test_scroll();

    set_text_attr(8'($urandom_range(0, 255)));
    test_random_traffic(30, 0, 0, 1'b0);
    set_text_attr(8'($urandom_range(0, 255)));
    test_random_traffic(30, 12, 12, 1'b1);
    set_text_attr(8'($urandom_range(0, 255)));
    test_random_traffic(30, 0, 12, 1'b0);
    set_text_attr(8'($urandom_range(0, 255)));
    test_random_traffic(30, 12, 0, 1'b0);

    wait_results_drained();
    repeat (20) @(posedge clk);
    $display("Sent %0d requests: %0d reads, %0d clears, %0d scrolls; %0d results checked.",
             n_requests, n_reads, n_clears, n_scrolls, n_checked);
    $display("Stimulus covered wrap, return, newline, unused requests and out-of-range reads.");
    if (errors == 0 && pending_results.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
